[rtl/assert_macros.svh]
// Assertion helpers shared by lpfs_ctrl and lpfs_dp.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, held off while in reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

[rtl/lpfs_pkg.sv]
package lpfs_pkg;

    // Operation codes carried by func
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // Number of line handles carried by one load beat
    localparam int LOAD_LINES = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_VICTIM,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic fetch_go;
        logic pick_free;
        logic start_scan;
        logic scan_rd;
        logic pick_victim;
        logic line_wr;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_load;
        logic full;
        logic scan_last;
        logic line_last;
        logic out_free;
    } sts_t;

    // One result beat
    typedef struct packed {
        logic [7:0]  frame_out;
        logic [15:0] line_out;
        logic        line_valid;
        logic        evicted;
        logic [7:0]  victim_frame;
        logic        page_fault;
    } res_t;

endpackage

[rtl/lpfs_ram.sv]
module lpfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lpfs_ctrl.sv]
`include "assert_macros.svh"

module lpfs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  lpfs_pkg::sts_t     sts,
    output lpfs_pkg::cmd_t     cmd
);

    lpfs_pkg::state_t state_reg;
    lpfs_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            lpfs_pkg::ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = lpfs_pkg::ST_DISPATCH;
                end
            end
            lpfs_pkg::ST_DISPATCH:
            begin
                if (!sts.is_load)
                begin
                    cmd.fetch_go = 1'b1;
                    state_next   = lpfs_pkg::ST_DONE;
                end
                else if (!sts.full)
                begin
                    cmd.pick_free = 1'b1;
                    state_next    = lpfs_pkg::ST_WRITE;
                end
                else
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = lpfs_pkg::ST_SCAN;
                end
            end
            lpfs_pkg::ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = lpfs_pkg::ST_SCAN_TAIL;
                end
            end
            lpfs_pkg::ST_SCAN_TAIL:
            begin
                // last stamp is compared at the end of this cycle
                state_next = lpfs_pkg::ST_VICTIM;
            end
            lpfs_pkg::ST_VICTIM:
            begin
                cmd.pick_victim = 1'b1;
                state_next      = lpfs_pkg::ST_WRITE;
            end
            lpfs_pkg::ST_WRITE:
            begin
                cmd.line_wr = 1'b1;
                if (sts.line_last)
                begin
                    state_next = lpfs_pkg::ST_DONE;
                end
            end
            lpfs_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lpfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpfs_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_accept_dispatch, clk, rst_n, (req_valid && !req_stall) |=> (state_reg == lpfs_pkg::ST_DISPATCH), "accepted beat not dispatched")
    `ASSERT_CLK(a_scan_ends, clk, rst_n, (state_reg == lpfs_pkg::ST_SCAN && sts.scan_last) |=> (state_reg == lpfs_pkg::ST_SCAN_TAIL), "scan overran last frame")

endmodule

[rtl/lpfs_dp.sv]
`include "assert_macros.svh"

module lpfs_dp #(
    parameter int NUM_FRAMES      = 256,
    parameter int LINES_PER_FRAME = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lpfs_pkg::cmd_t     cmd,
    output lpfs_pkg::sts_t     sts,
    input  logic               out_free,
    input  logic               func,
    input  logic [15:0]        line_zero,
    input  logic [15:0]        line_one,
    input  logic [15:0]        line_two,
    input  logic               fault_hint,
    input  logic [7:0]         frame_index,
    input  logic [1:0]         line_offset,
    output lpfs_pkg::res_t     res
);

    localparam int FW  = $clog2(NUM_FRAMES);
    localparam int FXW = (FW > 8) ? FW : 8;
    localparam int LW  = (LINES_PER_FRAME > 1) ? $clog2(LINES_PER_FRAME) : 1;
    localparam int OXW = (LW > 2) ? LW : 2;
    localparam int LINE_DEPTH = NUM_FRAMES << LW;

    // Captured beat
    logic           func_reg;
    logic [15:0]    line0_reg;
    logic [15:0]    line1_reg;
    logic [15:0]    line2_reg;
    logic           hint_reg;
    logic [FXW-1:0] fidx_reg;
    logic [1:0]     offs_reg;

    // Frame bookkeeping: used frames always form the prefix below fill_reg
    logic [FW:0]    fill_reg;
    logic [31:0]    counter_reg;
    logic [FW-1:0]  slot_reg;
    logic           evict_reg;
    logic [LW-1:0]  k_reg;
    logic           fetch_ok_reg;

    // Victim scan
    logic [FW-1:0]  scan_addr_reg;
    logic [FW-1:0]  rd_idx_reg;
    logic           rd_live_reg;
    logic           first_reg;
    logic [31:0]    best_reg;
    logic [FW-1:0]  best_idx_reg;

    logic [31:0]    stamp_rdata;
    logic [15:0]    line_rdata;
    logic           stamp_we;
    logic [FW-1:0]  stamp_waddr;
    logic [15:0]    line_wdata;
    logic [OXW-1:0] k_x;
    logic [OXW-1:0] offs_x;
    logic           in_range;
    logic           frame_used;
    logic           offs_ok;
    logic [FXW-1:0] slot_x;
    logic [7:0]     slot8;

    assign k_x      = OXW'(k_reg);
    assign offs_x   = OXW'(offs_reg);
    assign in_range = {1'b0, fidx_reg} < (FXW+1)'(NUM_FRAMES);
    assign frame_used = {1'b0, fidx_reg} < (FXW+1)'(fill_reg);
    assign offs_ok  = (OXW+1)'(offs_reg) < (OXW+1)'(LINES_PER_FRAME);
    assign slot_x   = FXW'(slot_reg);
    assign slot8    = slot_x[7:0];

    // Line data for the current write step; lines past the beat are zero
    always_comb
    begin
        if (k_x == OXW'(0))
        begin
            line_wdata = line0_reg;
        end
        else if (k_x == OXW'(1))
        begin
            line_wdata = line1_reg;
        end
        else if (k_x == OXW'(lpfs_pkg::LOAD_LINES - 1))
        begin
            line_wdata = line2_reg;
        end
        else
        begin
            line_wdata = '0;
        end
    end

    // Stamp write: a load stamps its slot on the last line, a fetch stamps its frame
    assign stamp_we    = (cmd.line_wr && (k_reg == LW'(LINES_PER_FRAME - 1)))
                         || (cmd.fetch_go && in_range);
    assign stamp_waddr = cmd.fetch_go ? fidx_reg[FW-1:0] : slot_reg;

    lpfs_ram #(
        .WIDTH (32),
        .DEPTH (NUM_FRAMES)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (counter_reg),
        .re    (cmd.scan_rd),
        .raddr (scan_addr_reg),
        .rdata (stamp_rdata)
    );

    lpfs_ram #(
        .WIDTH (16),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.line_wr),
        .waddr ({slot_reg, k_reg}),
        .wdata (line_wdata),
        .re    (cmd.fetch_go),
        .raddr ({fidx_reg[FW-1:0], offs_x[LW-1:0]}),
        .rdata (line_rdata)
    );

    // Beat capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            line0_reg <= line_zero;
            line1_reg <= line_one;
            line2_reg <= line_two;
            hint_reg  <= fault_hint;
            fidx_reg  <= FXW'(frame_index);
            offs_reg  <= line_offset;
        end
    end

    // Slot choice, line step, fetch check
    always_ff @(posedge clk)
    begin
        if (cmd.pick_free)
        begin
            slot_reg  <= fill_reg[FW-1:0];
            evict_reg <= 1'b0;
        end
        else if (cmd.pick_victim)
        begin
            slot_reg  <= best_idx_reg;
            evict_reg <= 1'b1;
        end
        if (cmd.pick_free || cmd.pick_victim)
        begin
            k_reg <= '0;
        end
        else if (cmd.line_wr)
        begin
            k_reg <= k_reg + LW'(1);
        end
        if (cmd.fetch_go)
        begin
            fetch_ok_reg <= in_range && frame_used && offs_ok;
        end
    end

    // Fill count and stamp counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            counter_reg <= '0;
        end
        else
        begin
            if (cmd.pick_free)
            begin
                fill_reg <= fill_reg + (FW+1)'(1);
            end
            if (cmd.fetch_go || (cmd.line_wr && (k_reg == LW'(LINES_PER_FRAME - 1))))
            begin
                counter_reg <= counter_reg + 32'd1;
            end
        end
    end

    // Scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_live_reg <= 1'b0;
            first_reg   <= 1'b0;
        end
        else
        begin
            rd_live_reg <= cmd.scan_rd;
            if (cmd.start_scan)
            begin
                first_reg <= 1'b1;
            end
            else if (rd_live_reg)
            begin
                first_reg <= 1'b0;
            end
        end
    end

    // Scan address and running minimum; strict compare keeps the lowest index on ties
    always_ff @(posedge clk)
    begin
        if (cmd.start_scan)
        begin
            scan_addr_reg <= '0;
        end
        else if (cmd.scan_rd)
        begin
            scan_addr_reg <= scan_addr_reg + FW'(1);
            rd_idx_reg    <= scan_addr_reg;
        end
        if (rd_live_reg && (first_reg || (stamp_rdata < best_reg)))
        begin
            best_reg     <= stamp_rdata;
            best_idx_reg <= rd_idx_reg;
        end
    end

    // Result beat
    always_comb
    begin
        res = '0;
        if (func_reg == lpfs_pkg::FUNC_LOAD)
        begin
            res.frame_out    = slot8;
            res.evicted      = evict_reg;
            res.victim_frame = evict_reg ? slot8 : 8'd0;
            res.page_fault   = evict_reg | hint_reg;
        end
        else
        begin
            res.line_out   = fetch_ok_reg ? line_rdata : 16'd0;
            res.line_valid = fetch_ok_reg;
        end
    end

    assign sts.is_load   = (func_reg == lpfs_pkg::FUNC_LOAD);
    assign sts.full      = (fill_reg == (FW+1)'(NUM_FRAMES));
    assign sts.scan_last = (scan_addr_reg == FW'(NUM_FRAMES - 1));
    assign sts.line_last = (k_reg == LW'(LINES_PER_FRAME - 1));
    assign sts.out_free  = out_free;

    `ASSERT_NEVER(a_fill_bound, clk, rst_n, fill_reg > (FW+1)'(NUM_FRAMES), "fill count past frame count")
    `ASSERT_CLK(a_victim_full, clk, rst_n, cmd.pick_victim |-> sts.full, "eviction with a free frame")
    `ASSERT_CLK(a_fetch_count, clk, rst_n, cmd.fetch_go |=> (counter_reg == $past(counter_reg) + 32'd1), "stamp counter missed a fetch")

endmodule

[rtl/lru_page_frame_store.sv]
// Frame store of NUM_FRAMES pages, LINES_PER_FRAME line handles each, with
// least-recently-used replacement. A load (func 0) takes the lowest free frame;
// once all frames are used it evicts the frame with the smallest recency stamp
// (lowest index on ties) and reports a page fault. A fetch (func 1) reads one
// line and refreshes the frame's stamp. One item is worked at a time. A load
// into a free frame writes its lines (one line memory write per cycle), and an
// evicting load first finds its victim by a minimum search that reads the
// stamp memory one frame per cycle. A finished result sits in an output
// register, so the next beat is taken while it waits. No clearing pass is
// needed after reset.
module lru_page_frame_store #(
    parameter int NUM_FRAMES      = 256,
    parameter int LINES_PER_FRAME = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        func,
    input  logic [15:0] line_zero,
    input  logic [15:0] line_one,
    input  logic [15:0] line_two,
    input  logic        fault_hint,
    input  logic [7:0]  frame_index,
    input  logic [1:0]  line_offset,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [7:0]  frame_out,
    output logic [15:0] line_out,
    output logic        line_valid,
    output logic        evicted,
    output logic [7:0]  victim_frame,
    output logic        page_fault
);

    lpfs_pkg::cmd_t cmd;
    lpfs_pkg::sts_t sts;
    lpfs_pkg::res_t res;
    lpfs_pkg::res_t res_reg;
    logic           rsp_valid_reg;
    logic           out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    lpfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lpfs_dp #(
        .NUM_FRAMES      (NUM_FRAMES),
        .LINES_PER_FRAME (LINES_PER_FRAME)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .out_free    (out_free),
        .func        (func),
        .line_zero   (line_zero),
        .line_one    (line_one),
        .line_two    (line_two),
        .fault_hint  (fault_hint),
        .frame_index (frame_index),
        .line_offset (line_offset),
        .res         (res)
    );

    // Output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg <= res;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign frame_out    = res_reg.frame_out;
    assign line_out     = res_reg.line_out;
    assign line_valid   = res_reg.line_valid;
    assign evicted      = res_reg.evicted;
    assign victim_frame = res_reg.victim_frame;
    assign page_fault   = res_reg.page_fault;

endmodule

[tb/lpfs_reply_checker.sv]
// Watches both channels of the frame store, keeps its own copy of the frame
// state, and compares every reply beat against the oldest one still due.
module lpfs_reply_checker #(
    parameter int NUM_FRAMES      = 256,
    parameter int LINES_PER_FRAME = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic        func,
    input  logic [15:0] line_zero,
    input  logic [15:0] line_one,
    input  logic [15:0] line_two,
    input  logic        fault_hint,
    input  logic [7:0]  frame_index,
    input  logic [1:0]  line_offset,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [7:0]  frame_out,
    input  logic [15:0] line_out,
    input  logic        line_valid,
    input  logic        evicted,
    input  logic [7:0]  victim_frame,
    input  logic        page_fault,
    output int          replies_due,
    output int          mismatches
);

    // Shadow frame state
    logic [15:0] frame_lines [NUM_FRAMES * LINES_PER_FRAME];
    bit          frame_busy  [NUM_FRAMES];
    bit   [31:0] frame_stamp [NUM_FRAMES];
    bit   [31:0] access_clock;

    lpfs_pkg::res_t due_replies [$];

    // Apply one request beat to the shadow state and build its reply
    task automatic access_frame_store(
        input  logic           op,
        input  logic [15:0]    l0,
        input  logic [15:0]    l1,
        input  logic [15:0]    l2,
        input  logic           hint,
        input  logic [7:0]     fidx,
        input  logic [1:0]     offs,
        output lpfs_pkg::res_t reply
    );
        int slot;
        bit evict;
        logic [15:0] fill;
        reply = '0;
        evict = 1'b0;
        if (op == lpfs_pkg::FUNC_LOAD)
        begin
            // lowest free frame first
            slot = NUM_FRAMES;
            for (int i = NUM_FRAMES - 1; i >= 0; i--)
            begin
                if (!frame_busy[i])
                    slot = i;
            end
            // all frames busy: oldest stamp goes, lowest index on ties
            if (slot == NUM_FRAMES)
            begin
                evict = 1'b1;
                slot = 0;
                for (int i = 1; i < NUM_FRAMES; i++)
                begin
                    if (frame_stamp[i] < frame_stamp[slot])
                        slot = i;
                end
            end
            for (int k = 0; k < LINES_PER_FRAME; k++)
            begin
                case (k)
                    0: fill = l0;
                    1: fill = l1;
                    2: fill = l2;
                    default: fill = 16'h0000;
                endcase
                frame_lines[slot * LINES_PER_FRAME + k] = fill;
            end
            frame_busy[slot] = 1'b1;
            frame_stamp[slot] = access_clock;
            reply.frame_out = 8'(slot);
            reply.evicted = evict;
            reply.victim_frame = evict ? 8'(slot) : 8'h00;
            reply.page_fault = evict | hint;
        end
        else
        begin
            // out-of-range frames touch nothing; free frames still get stamped
            if (int'(fidx) < NUM_FRAMES)
            begin
                frame_stamp[fidx] = access_clock;
                if (frame_busy[fidx] && int'(offs) < LINES_PER_FRAME)
                begin
                    reply.line_out = frame_lines[int'(fidx) * LINES_PER_FRAME + int'(offs)];
                    reply.line_valid = 1'b1;
                end
            end
        end
        access_clock = access_clock + 32'd1;
    endtask

    function automatic int field_differs(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Track beats on both channels
    always @(posedge clk or negedge rst_n)
    begin
        lpfs_pkg::res_t want;
        lpfs_pkg::res_t fresh;
        int   bad;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                frame_busy[i] = 1'b0;
                frame_stamp[i] = 32'd0;
            end
            access_clock = 32'd0;
            due_replies.delete();
            replies_due <= 0;
            mismatches <= 0;
        end
        else
        begin
            bad = 0;
            // reply beat against the oldest one due
            if (rsp_valid && !rsp_stall)
            begin
                if (due_replies.size() == 0)
                begin
                    $error("reply beat with nothing due: frame_out %0d line_out %0d",
                           frame_out, line_out);
                    bad++;
                end
                else
                begin
                    want = due_replies.pop_front();
                    bad += field_differs("frame_out", want.frame_out, frame_out);
                    bad += field_differs("line_out", want.line_out, line_out);
                    bad += field_differs("line_valid", want.line_valid, line_valid);
                    bad += field_differs("evicted", want.evicted, evicted);
                    bad += field_differs("victim_frame", want.victim_frame, victim_frame);
                    bad += field_differs("page_fault", want.page_fault, page_fault);
                end
            end
            // request beat: one reply per request
            if (req_valid && !req_stall)
            begin
                access_frame_store(func, line_zero, line_one, line_two, fault_hint,
                                   frame_index, line_offset, fresh);
                due_replies.push_back(fresh);
            end
            replies_due <= due_replies.size();
            mismatches <= mismatches + bad;
        end
    end

endmodule

[tb/lru_page_frame_store_tb.sv]
module lru_page_frame_store_tb;

    localparam int NUM_FRAMES      = 256;
    localparam int LINES_PER_FRAME = 3;
    localparam int RANDOM_BEATS    = 1050;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        func = lpfs_pkg::FUNC_LOAD;
    logic [15:0] line_zero = 16'h0000;
    logic [15:0] line_one = 16'h0000;
    logic [15:0] line_two = 16'h0000;
    logic        fault_hint = 1'b0;
    logic [7:0]  frame_index = 8'h00;
    logic [1:0]  line_offset = 2'b00;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [7:0]  frame_out;
    logic [15:0] line_out;
    logic        line_valid;
    logic        evicted;
    logic [7:0]  victim_frame;
    logic        page_fault;
    int          replies_due;
    int          mismatches;
    int          loads_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lru_page_frame_store #(
        .NUM_FRAMES      (NUM_FRAMES),
        .LINES_PER_FRAME (LINES_PER_FRAME)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .line_zero    (line_zero),
        .line_one     (line_one),
        .line_two     (line_two),
        .fault_hint   (fault_hint),
        .frame_index  (frame_index),
        .line_offset  (line_offset),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .frame_out    (frame_out),
        .line_out     (line_out),
        .line_valid   (line_valid),
        .evicted      (evicted),
        .victim_frame (victim_frame),
        .page_fault   (page_fault)
    );

    lpfs_reply_checker #(
        .NUM_FRAMES      (NUM_FRAMES),
        .LINES_PER_FRAME (LINES_PER_FRAME)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .line_zero    (line_zero),
        .line_one     (line_one),
        .line_two     (line_two),
        .fault_hint   (fault_hint),
        .frame_index  (frame_index),
        .line_offset  (line_offset),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .frame_out    (frame_out),
        .line_out     (line_out),
        .line_valid   (line_valid),
        .evicted      (evicted),
        .victim_frame (victim_frame),
        .page_fault   (page_fault),
        .replies_due  (replies_due),
        .mismatches   (mismatches)
    );

    // Offer one request beat and hold it until taken
    task automatic send_beat(
        input logic        op,
        input logic [15:0] l0,
        input logic [15:0] l1,
        input logic [15:0] l2,
        input logic        hint,
        input logic [7:0]  fidx,
        input logic [1:0]  offs
    );
        @(negedge clk);
        func = op;
        line_zero = l0;
        line_one = l1;
        line_two = l2;
        fault_hint = hint;
        frame_index = fidx;
        line_offset = offs;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        if (op == lpfs_pkg::FUNC_LOAD)
            loads_sent++;
    endtask

    // Drop valid for a number of cycles after a beat
    task automatic sender_gap(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic load_beat(input logic [15:0] l0, input logic [15:0] l1,
                             input logic [15:0] l2, input logic hint);
        send_beat(lpfs_pkg::FUNC_LOAD, l0, l1, l2, hint, 8'($urandom), 2'($urandom));
        sender_gap($urandom_range(0, 11));
    endtask

    task automatic fetch_beat(input logic [7:0] fidx, input logic [1:0] offs);
        send_beat(lpfs_pkg::FUNC_FETCH, 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom), fidx, offs);
        sender_gap($urandom_range(0, 11));
    endtask

    // Reply side: random stall per beat, two long hold-offs, two quiet stretches
    initial
    begin
        int gap;
        int taken;
        taken = 0;
        forever
        begin
            if (taken == 150 || taken == 800)
                gap = 600;
            else if ((taken >= 430 && taken < 560) || (taken >= 900 && taken < 950))
                gap = 0;
            else
                gap = $urandom_range(0, 11);
            if (gap > 0)
            begin
                @(negedge clk);
                rsp_stall = 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_stall = 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
            taken++;
        end
    end

    // Request side and verdict
    initial
    begin
        int load_pct;
        int reach;
        logic [7:0] fidx;
        logic [1:0] offs;
        logic [15:0] l0;
        logic [15:0] l1;
        logic [15:0] l2;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: free-frame fetches, bad offset, line extremes, hint
        fetch_beat(8'd0, 2'd0);
        fetch_beat(8'd255, 2'd3);
        load_beat(16'h0000, 16'h0000, 16'h0000, 1'b0);
        load_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        load_beat(16'h1234, 16'hABCD, 16'h5A5A, 1'b0);
        load_beat(16'h8001, 16'h7FFE, 16'h0001, 1'b1);
        fetch_beat(8'd0, 2'd0);
        fetch_beat(8'd0, 2'd1);
        fetch_beat(8'd0, 2'd2);
        fetch_beat(8'd0, 2'd3);
        fetch_beat(8'd1, 2'd0);
        fetch_beat(8'd1, 2'd2);
        fetch_beat(8'd2, 2'd1);
        fetch_beat(8'd3, 2'd3);
        fetch_beat(8'd3, 2'd2);
        fetch_beat(8'd255, 2'd0);
        fetch_beat(8'd4, 2'd1);
        load_beat(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        fetch_beat(8'd4, 2'd1);

        // random: load-heavy for the first 300 beats, then mixed, with evictions once the store fills
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            load_pct = (i < 300) ? 75 : 50;
            l0 = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom);
            l1 = ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom);
            l2 = 16'($urandom);
            if ($urandom_range(0, 99) < load_pct)
            begin
                send_beat(lpfs_pkg::FUNC_LOAD, l0, l1, l2, 1'($urandom),
                          8'($urandom), 2'($urandom));
            end
            else
            begin
                // mostly frames that hold a page, some noise anywhere
                reach = (loads_sent < NUM_FRAMES) ? loads_sent : NUM_FRAMES;
                if (reach > 0 && $urandom_range(0, 9) < 8)
                    fidx = 8'($urandom_range(0, reach - 1));
                else
                    fidx = 8'($urandom);
                if ($urandom_range(0, 9) < 9)
                    offs = 2'($urandom_range(0, LINES_PER_FRAME - 1));
                else
                    offs = 2'($urandom);
                send_beat(lpfs_pkg::FUNC_FETCH, l0, l1, l2, 1'($urandom), fidx, offs);
            end
            if (i == 700)
            begin
                // let the store drain completely before going on
                @(negedge clk);
                req_valid = 1'b0;
                while (replies_due != 0) @(negedge clk);
            end
            else if ((i >= 450 && i < 550) || (i >= 900 && i < 960))
                sender_gap(0);
            else
                sender_gap($urandom_range(0, 11));
        end
        @(negedge clk);
        req_valid = 1'b0;

        while (replies_due != 0) @(negedge clk);
        repeat (NUM_FRAMES + LINES_PER_FRAME + 40) @(posedge clk);
        if (mismatches == 0 && replies_due == 0)
            $display("lru_page_frame_store_tb: PASS");
        else
            $display("lru_page_frame_store_tb: FAIL");
        $finish;
    end

    // Run limit
    initial
    begin
        #15000000;
        $display("lru_page_frame_store_tb: FAIL");
        $finish;
    end

endmodule
